@@ src/mhpq_pkg.sv @@
// Package for the min-heap priority queue: widths, command and status codes.
// No dependencies.
`timescale 1ns / 1ps
package mhpq_pkg;
    localparam int ID_W = 16;
    localparam int WEIGHT_W = 32;
    localparam int COUNT_W = 11;
    localparam int CAPACITY_DEF = 1024;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_POP = 2'd1;
    localparam logic [1:0] CMD_CHG = 2'd2;
    localparam logic [1:0] CMD_NOP = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_ID = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [ID_W-1:0]     item_id;
        logic signed [WEIGHT_W-1:0] weight;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [ID_W-1:0]     out_id;
        logic signed [WEIGHT_W-1:0] out_weight;
        logic [COUNT_W-1:0]  entry_count;
    } rsp_word_t;
endpackage

@@ src/mhpq_if.sv @@
// Valid/ready channel carrying one word of a given type.
// No dependencies; the word type is given as a parameter.
`timescale 1ns / 1ps
interface mhpq_if #(parameter type word_t = logic);
    logic  valid;
    logic  ready;
    word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/min_heap_priority_queue.sv @@
// Min-heap priority queue top level: heap held in one synchronous RAM.
// Depends on mhpq_pkg and mhpq_if.
// An id search reads the entries one by one; sift up reads the parent and writes per level,
// sift down reads both children, then compares and writes per level; then the response is set.
// One word at a time; the RAM port is the bottleneck. Reset clears the count
// and control state only; heap RAM contents are undefined until written.
`timescale 1ns / 1ps
module min_heap_priority_queue #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input logic clk,
    input logic rst_n,
    mhpq_if.sink   cmd_in,
    mhpq_if.source rsp_out
);
    import mhpq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = ID_W + WEIGHT_W;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_SRCH_W, S_DISPATCH, S_POP_R, S_POP_W,
        S_UP_R, S_UP_W, S_DN_L, S_DN_R, S_DN_W, S_DN_CMP, S_OUT
    } state_t;

    logic [EW-1:0] mem [CAPACITY];
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

    state_t            state_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     idx_reg;
    logic [CW-1:0]     hole_reg;
    logic [CW-1:0]     child_reg;
    logic [1:0]        cmd_reg;
    logic [ID_W-1:0]   id_reg;
    logic signed [WEIGHT_W-1:0] w_reg;
    logic [EW-1:0]     left_reg;
    logic              found_reg;
    rsp_word_t         rsp_reg;
    logic              rsp_valid_reg;

    logic [ID_W-1:0]   rd_id;
    logic signed [WEIGHT_W-1:0] rd_w;
    logic signed [WEIGHT_W-1:0] left_w;
    logic [CW:0]       lchild;
    logic [CW-1:0]     parent;
    assign rd_id  = rdata[EW-1:WEIGHT_W];
    assign rd_w   = rdata[WEIGHT_W-1:0];
    assign left_w = left_reg[WEIGHT_W-1:0];
    assign lchild = {hole_reg, 1'b1};
    assign parent = (hole_reg - CW'(1)) >> 1;

    assign cmd_in.ready  = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign rsp_out.valid = rsp_valid_reg;
    assign rsp_out.data  = rsp_reg;

    always_comb
    begin
        we    = 1'b0;
        waddr = hole_reg[AW-1:0];
        wdata = {id_reg, w_reg};
        raddr = idx_reg[AW-1:0];
        case (state_reg)
            S_SRCH, S_SRCH_W: raddr = idx_reg[AW-1:0];
            S_DISPATCH:       raddr = '0;
            S_POP_R:          raddr = idx_reg[AW-1:0];
            S_UP_R:           raddr = parent[AW-1:0];
            S_DN_L:           raddr = lchild[AW-1:0];
            S_DN_R:           raddr = AW'(lchild + 1'b1);
            default:          raddr = idx_reg[AW-1:0];
        endcase
        case (state_reg)
            S_UP_W:
            begin
                we = 1'b1;
                if ((hole_reg != '0) && (w_reg < rd_w))
                    wdata = rdata;
            end
            S_DN_CMP:
            begin
                we = 1'b1;
                if ((lchild < {1'b0, count_reg}) && (left_w < w_reg))
                    wdata = left_reg;
            end
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            idx_reg       <= '0;
            hole_reg      <= '0;
            child_reg     <= '0;
            found_reg     <= 1'b0;
            cmd_reg       <= CMD_ADD;
        end
        else
        begin
            if (rsp_out.valid && rsp_out.ready)
                rsp_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_in.valid && cmd_in.ready)
                    begin
                        cmd_reg   <= cmd_in.data.cmd;
                        id_reg    <= cmd_in.data.item_id;
                        w_reg     <= cmd_in.data.weight;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        rsp_reg   <= '{((cmd_in.data.cmd == CMD_POP) && (count_reg == '0))
                                       ? ST_EMPTY : ST_OK,
                                       '0, '0, COUNT_W'(count_reg)};
                        if (cmd_in.data.cmd == CMD_POP)
                            state_reg <= (count_reg == '0) ? S_OUT : S_DISPATCH;
                        else if (cmd_in.data.cmd == CMD_ADD
                                 || cmd_in.data.cmd == CMD_CHG)
                            state_reg <= (count_reg == '0) ? S_DISPATCH : S_SRCH;
                        else
                            state_reg <= S_OUT;
                    end
                end
                S_SRCH:
                    state_reg <= S_SRCH_W;
                S_SRCH_W:
                begin
                    if (rd_id == id_reg)
                    begin
                        found_reg <= 1'b1;
                        state_reg <= S_DISPATCH;
                    end
                    else if (idx_reg + CW'(1) >= count_reg)
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_DISPATCH;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_SRCH;
                    end
                end
                S_DISPATCH:
                begin
                    case (cmd_reg)
                        CMD_ADD:
                        begin
                            if (found_reg)
                            begin
                                rsp_reg.status <= ST_ID;
                                state_reg <= S_OUT;
                            end
                            else if (count_reg >= CAP)
                            begin
                                rsp_reg.status <= ST_FULL;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                hole_reg  <= count_reg;
                                count_reg <= count_reg + CW'(1);
                                state_reg <= S_UP_R;
                            end
                        end
                        CMD_CHG:
                        begin
                            if (!found_reg)
                            begin
                                rsp_reg.status <= ST_ID;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                hole_reg <= idx_reg;
                                // rdata still holds the found entry's old weight
                                if (rd_w < w_reg)
                                    state_reg <= S_DN_L;
                                else
                                    state_reg <= S_UP_R;
                            end
                        end
                        default:
                        begin
                            idx_reg   <= count_reg - CW'(1);
                            count_reg <= count_reg - CW'(1);
                            state_reg <= S_POP_R;
                        end
                    endcase
                end
                S_POP_R:
                begin
                    left_reg  <= rdata;
                    state_reg <= S_POP_W;
                end
                S_POP_W:
                begin
                    rsp_reg  <= '{rsp_reg.status, left_reg[EW-1:WEIGHT_W], left_w,
                                  COUNT_W'(count_reg)};
                    id_reg   <= rd_id;
                    w_reg    <= rd_w;
                    hole_reg <= '0;
                    state_reg <= (count_reg == '0) ? S_OUT : S_DN_L;
                end
                S_UP_R:
                    state_reg <= S_UP_W;
                S_UP_W:
                begin
                    if ((hole_reg != '0) && (w_reg < rd_w))
                    begin
                        hole_reg  <= parent;
                        state_reg <= S_UP_R;
                    end
                    else
                        state_reg <= S_OUT;
                end
                S_DN_L:
                    state_reg <= S_DN_R;
                S_DN_R:
                begin
                    left_reg  <= rdata;
                    child_reg <= lchild[CW-1:0];
                    state_reg <= S_DN_W;
                end
                S_DN_W:
                begin
                    if ((lchild + 1'b1 < {1'b0, count_reg}) && (rd_w < left_w))
                    begin
                        left_reg  <= rdata;
                        child_reg <= lchild[CW-1:0] + CW'(1);
                    end
                    state_reg <= S_DN_CMP;
                end
                S_DN_CMP:
                begin
                    if ((lchild < {1'b0, count_reg}) && (left_w < w_reg))
                    begin
                        hole_reg  <= child_reg;
                        state_reg <= S_DN_L;
                    end
                    else
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (cmd_reg == CMD_ADD && rsp_reg.status == ST_OK)
                        rsp_reg.entry_count <= COUNT_W'(count_reg);
                    rsp_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP)
        else $error("count exceeds capacity");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_in.ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_one_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_in.valid && cmd_in.ready) |=> !cmd_in.ready)
        else $error("second word accepted while busy");
endmodule

@@ tb/sv/tb.sv @@
// Testbench for min_heap_priority_queue: drives add, pop, change-priority and no-op words,
// predicts each response with its own heap model and checks it field by field.
// Depends on mhpq_pkg, mhpq_if and the min_heap_priority_queue RTL.
`timescale 1ns / 1ps
module tb;
    import mhpq_pkg::*;

    localparam int HEAP_MAX = CAPACITY_DEF;
    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;

    mhpq_if #(.word_t(cmd_word_t)) cmd_ch ();
    mhpq_if #(.word_t(rsp_word_t)) rsp_ch ();

    min_heap_priority_queue dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_in(cmd_ch.sink),
        .rsp_out(rsp_ch.source)
    );

    cmd_word_t pending_words[$];
    rsp_word_t expected_rsp[$];

    logic [ID_W-1:0]            heap_ids[HEAP_MAX];
    logic signed [WEIGHT_W-1:0] heap_wts[HEAP_MAX];
    int heap_fill = 0;
    int peak_fill = 0;

    int send_idle_pct;
    int recv_stall_pct;
    bit send_hold;
    int words_sent = 0;
    int rsp_seen = 0;
    int mismatches = 0;
    int quiet_cycles;

    function automatic void queue_word(cmd_word_t w);
        pending_words.insert(pending_words.size(), w);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int find_entry(logic [ID_W-1:0] id);
        for (int i = 0; i < heap_fill; i++)
            if (heap_ids[i] == id)
                return i;
        return heap_fill;
    endfunction

    function automatic void bubble_up(int hole);
        logic [ID_W-1:0] id;
        logic signed [WEIGHT_W-1:0] w;
        int parent;
        id = heap_ids[hole];
        w = heap_wts[hole];
        while (hole > 0)
        begin
            parent = (hole - 1) / 2;
            if (!(w < heap_wts[parent]))
                break;
            heap_ids[hole] = heap_ids[parent];
            heap_wts[hole] = heap_wts[parent];
            hole = parent;
        end
        heap_ids[hole] = id;
        heap_wts[hole] = w;
    endfunction

    function automatic void bubble_down(int hole);
        logic [ID_W-1:0] id;
        logic signed [WEIGHT_W-1:0] w;
        int child;
        id = heap_ids[hole];
        w = heap_wts[hole];
        while (hole * 2 + 1 < heap_fill)
        begin
            child = hole * 2 + 1;
            if (child + 1 < heap_fill && heap_wts[child + 1] < heap_wts[child])
                child++;
            if (!(heap_wts[child] < w))
                break;
            heap_ids[hole] = heap_ids[child];
            heap_wts[hole] = heap_wts[child];
            hole = child;
        end
        heap_ids[hole] = id;
        heap_wts[hole] = w;
    endfunction

    function automatic rsp_word_t heap_apply(cmd_word_t c);
        rsp_word_t r;
        int pos;
        logic signed [WEIGHT_W-1:0] prior;
        r = '0;
        r.status = ST_OK;
        case (c.cmd)
            CMD_ADD:
                if (find_entry(c.item_id) < heap_fill)
                    r.status = ST_ID;
                else if (heap_fill >= HEAP_MAX)
                    r.status = ST_FULL;
                else
                begin
                    heap_ids[heap_fill] = c.item_id;
                    heap_wts[heap_fill] = c.weight;
                    heap_fill++;
                    bubble_up(heap_fill - 1);
                end
            CMD_POP:
                if (heap_fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.out_id = heap_ids[0];
                    r.out_weight = heap_wts[0];
                    heap_fill--;
                    if (heap_fill > 0)
                    begin
                        heap_ids[0] = heap_ids[heap_fill];
                        heap_wts[0] = heap_wts[heap_fill];
                        bubble_down(0);
                    end
                end
            CMD_CHG:
            begin
                pos = find_entry(c.item_id);
                if (pos >= heap_fill)
                    r.status = ST_ID;
                else
                begin
                    prior = heap_wts[pos];
                    heap_wts[pos] = c.weight;
                    if (prior < c.weight)
                        bubble_down(pos);
                    else if (c.weight < prior)
                        bubble_up(pos);
                end
            end
            default: ;
        endcase
        if (heap_fill > peak_fill)
            peak_fill = heap_fill;
        r.entry_count = heap_fill[COUNT_W-1:0];
        return r;
    endfunction

    // driver: a word once raised stays until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.data <= '0;
        end
        else if (!cmd_ch.valid || cmd_ch.ready)
        begin
            if (!send_hold && pending_words.size() > 0 &&
                $urandom_range(99) >= send_idle_pct)
            begin
                cmd_word_t w;
                w = pending_words.pop_front();
                cmd_ch.data <= w;
                cmd_ch.valid <= 1'b1;
                expected_rsp.insert(expected_rsp.size(), heap_apply(w));
                words_sent++;
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                rsp_word_t e;
                rsp_seen++;
                if (expected_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response %p", rsp_ch.data);
                end
                else
                begin
                    e = expected_rsp.pop_front();
                    if (rsp_ch.data.status !== e.status ||
                        rsp_ch.data.out_id !== e.out_id ||
                        rsp_ch.data.out_weight !== e.out_weight ||
                        rsp_ch.data.entry_count !== e.entry_count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p got %p", e, rsp_ch.data);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic cmd_word_t mk(logic [1:0] c, logic [ID_W-1:0] id,
                                     logic signed [WEIGHT_W-1:0] w);
        cmd_word_t x;
        x.cmd = c;
        x.item_id = id;
        x.weight = w;
        return x;
    endfunction

    function automatic cmd_word_t random_word();
        int pick;
        logic [1:0] c;
        logic [ID_W-1:0] id;
        logic signed [WEIGHT_W-1:0] w;
        pick = $urandom_range(99);
        c = (pick < 45) ? CMD_ADD : (pick < 75) ? CMD_POP : (pick < 95) ? CMD_CHG : CMD_NOP;
        id = ($urandom_range(9) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(47));
        if ($urandom_range(1) == 0)
            w = $urandom;
        else
            w = $signed($urandom_range(8)) - 4 <<< 16;
        return mk(c, id, w);
    endfunction

    task automatic drain();
        @(negedge clk);
        while (pending_words.size() > 0 || expected_rsp.size() > 0 || cmd_ch.valid)
            @(negedge clk);
    endtask

    task automatic run_batch(int n, int idle, int stall);
        @(negedge clk);
        send_hold = 1'b1;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++)
            queue_word(random_word());
        send_hold = 1'b0;
        drain();
    endtask

    initial
    begin
        send_hold = 1'b1;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed corners
        queue_word(mk(CMD_POP, 16'd0, 32'sd0));
        queue_word(mk(CMD_CHG, 16'd5, 32'sd7));
        queue_word(mk(CMD_ADD, 16'd0, 32'sh8000_0000));
        queue_word(mk(CMD_ADD, 16'hFFFF, 32'sh7FFF_FFFF));
        queue_word(mk(CMD_ADD, 16'd0, 32'sd5));
        queue_word(mk(CMD_ADD, 16'h5A5A, 32'sd0));
        queue_word(mk(CMD_ADD, 16'hA5A5, 32'sd0));
        queue_word(mk(CMD_CHG, 16'hFFFF, 32'sh8000_0000));
        queue_word(mk(CMD_CHG, 16'd0, 32'sh7FFF_FFFF));
        queue_word(mk(CMD_CHG, 16'h5A5A, 32'sd0));
        queue_word(mk(CMD_CHG, 16'h1234, 32'sd1));
        queue_word(mk(CMD_NOP, 16'hFFFF, 32'shFFFF_FFFF));
        repeat (5)
            queue_word(mk(CMD_POP, 16'd0, 32'sd0));
        queue_word(mk(CMD_POP, 16'd0, 32'sd0));
        send_hold = 1'b0;
        drain();

        run_batch(130, 0, 0);
        run_batch(130, 57, 0);
        run_batch(130, 0, 57);
        run_batch(130, 21, 21);

        repeat (50) @(negedge clk);
        $display("covered %0d command words and %0d responses, heap peak %0d entries",
                 words_sent, rsp_seen, peak_fill);
        $display("phases: directed corners, no idle, sender idle, receiver stall, both");
        if (mismatches == 0 && expected_rsp.size() == 0)
            $display("tb: success");
        else
        begin
            $display("%0d mismatches, %0d responses missing", mismatches, expected_rsp.size());
            $display("tb: failure");
        end
        $finish;
    end
endmodule
